// ===== sv/rsl_pkg.sv =====
// Package with shared types and constants for the simulcast layer ramp.
package rsl_pkg;

    localparam int RATE_W = 28;
    localparam int TIME_W = 48;
    localparam int QUOT_W = 51;
    localparam logic [TIME_W-1:0] FAIL_WINDOW_US = 48'd7000000;
    localparam logic signed [5:0] CNT_LIMIT = 6'sd23;
    localparam logic signed [5:0] SWITCH_LEVEL = 6'sd20;
    localparam logic signed [31:0] Q16_ONE = 32'sd65536;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_LAYERS = 3'd1;
    localparam logic [2:0] REG_LOW = 3'd2;
    localparam logic [2:0] REG_MID = 3'd3;
    localparam logic [2:0] REG_HIGH = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCALE,
        ST_TENTH,
        ST_PART,
        ST_FAIL,
        ST_DECIDE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic scale;
        logic tenth;
        logic part;
        logic fail_adj;
        logic decide;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic active;
    } t_status;

endpackage

// ===== sv/rsl_ctrl.sv =====
// Controller state machine that sequences one report through the datapath.
module rsl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  rsl_pkg::t_status i_status,
    output rsl_pkg::t_cmd    o_cmd
);
    import rsl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_status.active) n_state = ST_DECIDE;
                else if (i_status.div_done) n_state = ST_SCALE;
            end
            ST_SCALE: n_state = ST_TENTH;
            ST_TENTH: n_state = ST_PART;
            ST_PART: n_state = ST_FAIL;
            ST_FAIL: n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_DIV: o_cmd.div_step = i_status.active;
            ST_SCALE: o_cmd.scale = 1'b1;
            ST_TENTH: o_cmd.tenth = 1'b1;
            ST_PART: o_cmd.part = 1'b1;
            ST_FAIL: o_cmd.fail_adj = 1'b1;
            ST_DECIDE: o_cmd.decide = 1'b1;
            ST_OUT: begin
                o_valid = 1'b1;
                o_cmd.finish = !i_stall;
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

// ===== sv/rsl_dp.sv =====
// Datapath with the divider, rate scaling, counter and ramp state.
module rsl_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rsl_pkg::t_cmd           i_cmd,
    output rsl_pkg::t_status        o_status,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [27:0]             i_cfg_data,
    input  logic [27:0]             i_est_rate,
    input  logic [47:0]             i_now_us,
    input  logic signed [2:0]       i_sent_substream,
    input  logic signed [2:0]       i_sent_temporal,
    input  logic signed [2:0]       i_want_substream,
    input  logic signed [2:0]       i_want_substream_pending,
    input  logic signed [2:0]       i_want_temporal,
    input  logic                    i_source_simulcasts,
    output logic signed [2:0]       o_substream_cap,
    output logic signed [2:0]       o_temporal_cap,
    output logic                    o_switched,
    output logic                    o_switched_up,
    output logic                    o_ramp_failed,
    output logic signed [5:0]       o_hysteresis_level,
    output logic                    o_disabled
);
    import rsl_pkg::*;

    logic [1:0]  r_mode, r_layers;
    logic [27:0] r_low, r_mid, r_high;

    logic signed [5:0]  r_cnt;
    logic signed [31:0] r_avg;
    logic [27:0] r_prev;
    logic        r_prev_ok;
    logic signed [3:0] r_last_req, r_fail_pos;
    logic [7:0]  r_fail_cnt;
    logic [47:0] r_ramp_t;
    logic signed [2:0] r_sub_cap, r_temp_cap;
    logic        r_off;
    logic        r_sw, r_sw_up, r_failed;

    // Latched report word.
    logic [27:0] r_b;
    logic [47:0] r_now;
    logic signed [2:0] r_s_sub, r_s_tmp, r_w_sub, r_w_pend, r_w_tmp;
    logic        r_simul;
    logic        r_active;

    // Restoring divider: quotient of b*6553600 / prev.
    logic [QUOT_W-1:0] r_num;
    logic [QUOT_W-1:0] r_quo;
    logic [28:0] r_rem;
    logic [5:0]  r_div_cnt;
    logic signed [31:0] r_change;

    // Scaled position rates and the parts of the failure factor.
    logic [35:0] r_cr, r_hr;
    logic [29:0] r_cq, r_hq;
    logic [11:0] r_ct, r_ht;
    logic [35:0] r_cnq, r_hnq;

    logic [28:0] w_rem_sh;
    logic [28:0] w_rem_sub;

    function automatic logic [2:0] f_pos(input logic signed [2:0] sub,
                                         input logic signed [2:0] tmp);
        logic [2:0] p;
        p = (sub == 3'sd1) ? 3'd2 : (sub == 3'sd2) ? 3'd4 : 3'd0;
        if (tmp == -3'sd1 || tmp == 3'sd2) p = p + 3'd1;
        return p;
    endfunction

    logic [2:0] w_cur, w_req;
    logic       w_low_t;
    logic [2:0] w_lower, w_higher;
    logic signed [2:0] w_st;

    always_comb begin
        w_cur = f_pos(r_s_sub, r_s_tmp);
        w_req = f_pos((r_w_pend == -3'sd1) ? r_w_sub : r_w_pend, r_w_tmp);
        w_low_t = (r_w_tmp == 3'sd0) || (r_w_tmp == 3'sd1);
        w_lower = w_cur;
        if (w_cur > 3'd0) begin
            w_lower = w_cur - 3'd1;
            if (w_lower[0] && w_low_t) w_lower = w_lower - 3'd1;
        end
        w_st = (r_w_sub == -3'sd1) ? 3'sd2 : r_w_sub;
        w_higher = w_cur;
        if (w_cur < 3'd5) begin
            w_higher = w_cur + 3'd1;
            if (w_higher[0] && w_low_t) w_higher = w_higher + 3'd1;
            if (w_higher > 3'd3 && w_st < 3'sd2) w_higher = 3'd0;
            else if (w_higher > 3'd1 && w_st < 3'sd1) w_higher = 3'd0;
        end
    end

    // Exact floor(x/5) for any x below 2^30.
    function automatic logic [29:0] f_div5(input logic [29:0] x);
        logic [63:0] p;
        p = {34'd0, x} * 64'd3435973837;
        return p[63:34];
    endfunction

    // Exact floor(x/10) for the small products of the failure factor.
    function automatic logic [11:0] f_tenth(input logic [11:0] x);
        logic [27:0] p;
        p = {16'd0, x} * 28'd6554;
        return p[27:16];
    endfunction

    function automatic logic [27:0] f_base(input logic [2:0] pos,
                                           input logic [1:0] layers,
                                           input logic [27:0] lo,
                                           input logic [27:0] mi,
                                           input logic [27:0] hi);
        case (pos)
            3'd0, 3'd1: return lo;
            3'd2, 3'd3: return (layers > 2'd1) ? mi : 28'd0;
            3'd4, 3'd5: return (layers > 2'd2) ? hi : 28'd0;
            default: return 28'd0;
        endcase
    endfunction

    function automatic logic [35:0] f_rate(input logic [2:0] pos,
                                           input logic [1:0] layers,
                                           input logic [27:0] lo,
                                           input logic [27:0] mi,
                                           input logic [27:0] hi);
        logic [27:0] base;
        logic [35:0] r;
        base = f_base(pos, layers, lo, mi, hi);
        if (pos[0]) r = {8'd0, base};
        else r = {6'd0, f_div5({1'b0, base, 1'b0} + {2'd0, base})};
        return r;
    endfunction

    logic [35:0] w_cr_base, w_hr_base;
    assign w_cr_base = f_rate(w_cur, r_layers, r_low, r_mid, r_high);
    assign w_hr_base = f_rate(w_higher, r_layers, r_low, r_mid, r_high);

    logic [3:0] w_req_s;
    assign w_req_s = {1'b0, w_req};

    // Failed position as seen after this report's request check.
    logic signed [3:0] w_fp_eff;
    assign w_fp_eff = ($signed(w_req_s) != r_last_req && w_req < w_cur) ? -4'sd1 :
        r_fail_pos;

    logic [29:0] w_crem, w_hrem;
    assign w_crem = r_cr[29:0] - ({r_cq[26:0], 3'b0} + {r_cq[28:0], 1'b0});
    assign w_hrem = r_hr[29:0] - ({r_hq[26:0], 3'b0} + {r_hq[28:0], 1'b0});

    // Decision logic.
    logic signed [5:0]  n_cnt;
    logic signed [31:0] w_cv;
    logic signed [36:0] w_cv5;
    logic [39:0] w_b5, w_b10, w_cr4, w_cr9, w_hr6, w_hr11;
    logic [47:0] w_dt;
    logic signed [3:0] n_fail_pos;
    logic [7:0]  n_fail_cnt;
    logic [47:0] n_ramp_t;
    logic signed [2:0] n_sub_cap, n_temp_cap;
    logic        n_off, n_sw, n_sw_up, n_failed;
    logic signed [32:0] w_avg_sum;
    logic signed [31:0] n_avg;
    logic [2:0]  w_tgt;
    logic signed [3:0] n_last_req;

    always_comb begin
        n_cnt = r_cnt;
        n_fail_pos = r_fail_pos;
        n_fail_cnt = r_fail_cnt;
        n_ramp_t = r_ramp_t;
        n_sub_cap = r_sub_cap;
        n_temp_cap = r_temp_cap;
        n_off = r_off;
        n_sw = 1'b0;
        n_sw_up = 1'b0;
        n_failed = 1'b0;
        n_last_req = r_last_req;
        w_tgt = '0;
        w_dt = '0;
        if ($signed(w_req_s) != r_last_req) begin
            n_last_req = $signed(w_req_s);
            if (w_req < w_cur) begin
                n_fail_pos = -4'sd1;
                n_fail_cnt = '0;
                n_ramp_t = '0;
            end
        end
        w_cv = (r_change > r_avg) ? r_change : r_avg;
        w_cv5 = 37'(w_cv) * 37'sd5;
        w_b5 = 40'(r_b) * 40'd5;
        w_b10 = 40'(r_b) * 40'd10;
        w_cr4 = 40'(r_cr) * 40'd4;
        w_cr9 = 40'(r_cr) * 40'd9;
        w_hr6 = 40'(r_hr) * 40'd6;
        w_hr11 = 40'(r_hr) * 40'd11;
        if (r_prev_ok) begin
            if (w_cur > 3'd0 && 36'(r_b) < r_cr) begin
                if (w_b5 < w_cr4 && w_cv5 < 37'(Q16_ONE)) n_cnt = n_cnt - 6'sd4;
                else if (w_b10 < w_cr9 && 33'(w_cv) * 33'sd2 < 33'(Q16_ONE))
                    n_cnt = n_cnt - 6'sd2;
                else if (w_cv < Q16_ONE) n_cnt = n_cnt - 6'sd1;
            end else if (36'(r_b) > r_cr) begin
                if (n_cnt < 6'sd0) n_cnt = n_cnt + 6'sd1;
                if (r_hr != '0 && 36'(r_b) > r_hr) begin
                    if (w_b5 > w_hr6) n_cnt = n_cnt + 6'sd4;
                    else if (w_b10 > w_hr11) n_cnt = n_cnt + 6'sd2;
                    else n_cnt = n_cnt + 6'sd1;
                end
            end
            if (n_cnt > CNT_LIMIT) n_cnt = CNT_LIMIT;
            if (n_cnt < -CNT_LIMIT) n_cnt = -CNT_LIMIT;
        end
        if (n_ramp_t != '0) begin
            w_dt = r_now - n_ramp_t;
            if (n_fail_pos >= 4'sd0 && w_dt > FAIL_WINDOW_US &&
                $signed({1'b0, w_cur}) >= n_fail_pos) begin
                n_fail_pos = -4'sd1;
                n_fail_cnt = '0;
            end
        end
        if (n_cnt <= -SWITCH_LEVEL || n_cnt >= SWITCH_LEVEL) begin
            if (r_simul) begin
                if (n_cnt < 6'sd0) begin
                    if (n_ramp_t != '0) begin
                        if (w_dt < FAIL_WINDOW_US) begin
                            n_fail_pos = $signed({1'b0, w_cur});
                            if (n_fail_cnt != 8'hFF) n_fail_cnt = n_fail_cnt + 8'd1;
                            n_failed = 1'b1;
                        end
                        n_ramp_t = '0;
                    end
                    w_tgt = w_lower;
                    n_sw = 1'b1;
                end else if (w_higher <= 3'd5) begin
                    w_tgt = w_higher;
                    n_ramp_t = r_now;
                    n_sw = 1'b1;
                    n_sw_up = 1'b1;
                end
                if (n_sw) begin
                    n_sub_cap = (w_tgt < 3'd2) ? 3'sd0 : (w_tgt < 3'd4) ? 3'sd1 : -3'sd1;
                    n_temp_cap = w_tgt[0] ? -3'sd1 : 3'sd1;
                end
                n_cnt = 6'sd0;
            end else begin
                n_off = 1'b1;
            end
        end
        w_avg_sum = 33'(r_avg) + 33'(r_change);
        if (r_avg != '0) n_avg = 32'((w_avg_sum + 33'(w_avg_sum[32])) >>> 1);
        else n_avg = r_change;
    end

    assign w_rem_sh = {r_rem[27:0], r_num[QUOT_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_prev};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_b <= i_est_rate;
            r_now <= i_now_us;
            r_s_sub <= i_sent_substream;
            r_s_tmp <= i_sent_temporal;
            r_w_sub <= i_want_substream;
            r_w_pend <= i_want_substream_pending;
            r_w_tmp <= i_want_temporal;
            r_simul <= i_source_simulcasts;
            r_num <= QUOT_W'({23'd0, i_est_rate} * 51'd6553600);
            r_quo <= '0;
            r_rem <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[QUOT_W-2:0], 1'b0};
            if (w_rem_sh >= {1'b0, r_prev}) begin
                r_rem <= w_rem_sub;
                r_quo <= {r_quo[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[QUOT_W-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + 6'd1;
        end
        if (i_cmd.scale) begin
            if (r_prev == '0) r_change <= '0;
            else if (r_quo >= 51'd2154037248) r_change <= 32'h7FFFFFFF;
            else r_change <= r_quo[31:0] - 32'd6553600;
            r_cr <= w_cr_base;
            r_hr <= (w_higher <= w_cur) ? 36'd0 : w_hr_base;
        end
        if (i_cmd.tenth) begin
            r_cq <= f_div5({2'd0, r_cr[28:1]});
            r_hq <= f_div5({2'd0, r_hr[28:1]});
        end
        if (i_cmd.part) begin
            r_ct <= {4'd0, r_fail_cnt} * {8'd0, w_crem[3:0]};
            r_ht <= {4'd0, r_fail_cnt} * {8'd0, w_hrem[3:0]};
            r_cnq <= {28'd0, r_fail_cnt} * {6'd0, r_cq};
            r_hnq <= {28'd0, r_fail_cnt} * {6'd0, r_hq};
        end
        if (i_cmd.fail_adj) begin
            if (w_fp_eff == $signed({1'b0, w_cur}))
                r_cr <= r_cr + r_cnq + {24'd0, f_tenth(r_ct)};
            if (w_fp_eff == $signed({1'b0, w_higher}))
                r_hr <= r_hr + r_hnq + {24'd0, f_tenth(r_ht)};
        end
    end

    assign o_status.div_done = (r_div_cnt == 6'(QUOT_W - 1));
    assign o_status.active = r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_layers <= '0;
            r_low <= '0;
            r_mid <= '0;
            r_high <= '0;
            r_cnt <= '0;
            r_avg <= '0;
            r_prev <= '0;
            r_prev_ok <= 1'b0;
            r_last_req <= -4'sd1;
            r_fail_pos <= -4'sd1;
            r_fail_cnt <= '0;
            r_ramp_t <= '0;
            r_sub_cap <= -3'sd1;
            r_temp_cap <= -3'sd1;
            r_off <= 1'b0;
            r_sw <= 1'b0;
            r_sw_up <= 1'b0;
            r_failed <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE: begin
                        r_mode <= i_cfg_data[1:0];
                        if (i_cfg_data[1:0] == 2'd1) begin
                            r_sub_cap <= 3'sd0;
                            r_temp_cap <= 3'sd1;
                        end
                    end
                    REG_LAYERS: begin
                        r_layers <= i_cfg_data[1:0];
                        r_off <= 1'b0;
                    end
                    REG_LOW: r_low <= i_cfg_data;
                    REG_MID: r_mid <= i_cfg_data;
                    REG_HIGH: r_high <= i_cfg_data;
                    default: r_mode <= r_mode;
                endcase
            end
            if (i_cmd.load) begin
                r_active <= (i_cfg_we ? 1'b0 : 1'b1) &&
                    (r_mode == 2'd1 || r_mode == 2'd2) && i_est_rate != '0 &&
                    r_layers != '0 && !r_off && i_sent_substream != -3'sd1;
                r_sw <= 1'b0;
                r_sw_up <= 1'b0;
                r_failed <= 1'b0;
            end
            if (i_cmd.decide) begin
                if (r_active) begin
                    r_cnt <= n_cnt;
                    r_avg <= n_avg;
                    r_last_req <= n_last_req;
                    r_fail_pos <= n_fail_pos;
                    r_fail_cnt <= n_fail_cnt;
                    r_ramp_t <= n_ramp_t;
                    r_sub_cap <= n_sub_cap;
                    r_temp_cap <= n_temp_cap;
                    r_off <= n_off;
                    r_sw <= n_sw;
                    r_sw_up <= n_sw_up;
                    r_failed <= n_failed;
                end
                if (r_b != '0) begin
                    r_prev <= r_b;
                    r_prev_ok <= 1'b1;
                end
            end
        end
    end

    assign o_substream_cap = r_sub_cap;
    assign o_temporal_cap = r_temp_cap;
    assign o_switched = r_sw;
    assign o_switched_up = r_sw_up;
    assign o_ramp_failed = r_failed;
    assign o_hysteresis_level = r_cnt;
    assign o_disabled = r_off;

endmodule

// ===== sv/remb_simulcast_layer_ramp.sv =====
// Top level of the bandwidth-estimate driven simulcast layer ramp.
//
// An input word carries one bandwidth report with the forwarded and requested
// layers; it is taken when i_valid is high and o_stall is low. One result word
// is produced per input word and is offered on o_valid until i_stall is low.
// An active report passes from acceptance to o_valid through the bit-serial
// restoring divider that forms the percent change, the scale, tenth, part and
// fail states that scale the position rates and apply the failure factor, and
// the counter decision. Idle reports skip the divider and scaling and go
// straight to the decision. Items are handled one at a time: a new word is
// taken only after the result of the last one has been handed off.
// While the receiver stalls, the result holds and no new word is accepted.
// Reset clears the counter, averages, failure record and caps to their idle
// values; configuration writes are taken at any edge with i_cfg_we high and
// are meant to arrive while no word is in flight.
module remb_simulcast_layer_ramp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [27:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [27:0]       i_est_rate,
    input  logic [47:0]       i_now_us,
    input  logic signed [2:0] i_sent_substream,
    input  logic signed [2:0] i_sent_temporal,
    input  logic signed [2:0] i_want_substream,
    input  logic signed [2:0] i_want_substream_pending,
    input  logic signed [2:0] i_want_temporal,
    input  logic              i_source_simulcasts,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [2:0] o_substream_cap,
    output logic signed [2:0] o_temporal_cap,
    output logic              o_switched,
    output logic              o_switched_up,
    output logic              o_ramp_failed,
    output logic signed [5:0] o_hysteresis_level,
    output logic              o_disabled
);
    import rsl_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rsl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    rsl_dp u_dp (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (w_cmd),
        .o_status                 (w_status),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_index              (i_cfg_index),
        .i_cfg_data               (i_cfg_data),
        .i_est_rate               (i_est_rate),
        .i_now_us                 (i_now_us),
        .i_sent_substream         (i_sent_substream),
        .i_sent_temporal          (i_sent_temporal),
        .i_want_substream         (i_want_substream),
        .i_want_substream_pending (i_want_substream_pending),
        .i_want_temporal          (i_want_temporal),
        .i_source_simulcasts      (i_source_simulcasts),
        .o_substream_cap          (o_substream_cap),
        .o_temporal_cap           (o_temporal_cap),
        .o_switched               (o_switched),
        .o_switched_up            (o_switched_up),
        .o_ramp_failed            (o_ramp_failed),
        .o_hysteresis_level       (o_hysteresis_level),
        .o_disabled               (o_disabled)
    );

endmodule

// ===== tb/tb_remb_simulcast_layer_ramp.sv =====
// Self-checking testbench for the bandwidth-estimate driven simulcast layer ramp.
`timescale 1ns / 100ps

module tb_remb_simulcast_layer_ramp;
    import rsl_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int SETTLE_CYCLES = 60;
    localparam longint RATE_MAX = 268435455;
    localparam longint TIME_MASK = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [27:0]       est;
        logic [47:0]       now;
        logic signed [2:0] ss;
        logic signed [2:0] st;
        logic signed [2:0] ws;
        logic signed [2:0] wp;
        logic signed [2:0] wt;
        logic              sim;
    } t_report;

    typedef struct packed {
        logic signed [2:0] sub;
        logic signed [2:0] tmp;
        logic              sw;
        logic              up;
        logic              fl;
        logic signed [5:0] lvl;
        logic              dis;
    } t_caps;

    typedef struct packed {
        t_report w;
        logic    has_exp;
        t_caps   exp;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_index = REG_MODE;
    logic [27:0]       i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [27:0]       i_est_rate = '0;
    logic [47:0]       i_now_us = '0;
    logic signed [2:0] i_sent_substream = '0;
    logic signed [2:0] i_sent_temporal = '0;
    logic signed [2:0] i_want_substream = '0;
    logic signed [2:0] i_want_substream_pending = '0;
    logic signed [2:0] i_want_temporal = '0;
    logic              i_source_simulcasts = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic signed [2:0] o_substream_cap;
    logic signed [2:0] o_temporal_cap;
    logic              o_switched;
    logic              o_switched_up;
    logic              o_ramp_failed;
    logic signed [5:0] o_hysteresis_level;
    logic              o_disabled;

    remb_simulcast_layer_ramp u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state and its copy of the registers.
    int     mode_r, layers_r;
    longint rate_lo, rate_mid, rate_hi;
    int     sw_cnt, last_req, fail_pos, fail_cnt, sub_cap_p, temp_cap_p;
    longint avg_chg, prev_rate, ramp_t;
    bit     prev_ok, off_p;

    t_caps  caps_due[$];
    int     errors = 0;
    int     words_in = 0, words_out = 0, switches = 0, ups = 0, fails = 0;
    int     idle_mode = 0;
    int     hold_cycles = 0;
    int     quiet = 0;
    longint t_now = 0;

    function automatic int layer_pos(int sub, int tp);
        int p;
        p = (sub == 1) ? 2 : (sub == 2) ? 4 : 0;
        if (tp == -1 || tp == 2) p++;
        return p;
    endfunction

    function automatic longint pos_rate(int p);
        longint r;
        r = 0;
        case (p)
            0: r = rate_lo * 3 / 5;
            1: r = rate_lo;
            2: if (layers_r > 1) r = rate_mid * 3 / 5;
            3: if (layers_r > 1) r = rate_mid;
            4: if (layers_r > 2) r = rate_hi * 3 / 5;
            5: if (layers_r > 2) r = rate_hi;
            default: r = 0;
        endcase
        if (fail_pos >= 0 && fail_pos == p) r = r * (10 + fail_cnt) / 10;
        return r;
    endfunction

    function automatic bit load_caps(int p);
        if (p < 0 || p > 5) return 1'b0;
        sub_cap_p = (p < 2) ? 0 : (p < 4) ? 1 : -1;
        temp_cap_p = (p & 1) ? -1 : 1;
        return 1'b1;
    endfunction

    function automatic void model_reset();
        mode_r = 0; layers_r = 0; rate_lo = 0; rate_mid = 0; rate_hi = 0;
        sw_cnt = 0; avg_chg = 0; prev_rate = 0; prev_ok = 0;
        last_req = -1; fail_pos = -1; fail_cnt = 0; ramp_t = 0;
        sub_cap_p = -1; temp_cap_p = -1; off_p = 0;
    endfunction

    function automatic void model_write(logic [2:0] idx, logic [27:0] d);
        case (idx)
            REG_MODE: begin
                mode_r = d[1:0];
                if (mode_r == 1) begin
                    sub_cap_p = 0;
                    temp_cap_p = 1;
                end
            end
            REG_LAYERS: begin
                layers_r = d[1:0];
                off_p = 0;
            end
            REG_LOW: rate_lo = d;
            REG_MID: rate_mid = d;
            REG_HIGH: rate_hi = d;
            default: ;
        endcase
    endfunction

    function automatic t_caps ramp_predict(t_report w);
        longint b, chg, cv, cr, hr, dt, avg;
        int     s_sub, s_tmp, w_sub, w_pend, w_tmp, cur, req, lo, hi, stp;
        bit     low_t, sw, up, fl;
        t_caps  r;
        b = w.est;
        s_sub = w.ss; s_tmp = w.st; w_sub = w.ws; w_pend = w.wp; w_tmp = w.wt;
        sw = 0; up = 0; fl = 0;
        if ((mode_r == 1 || mode_r == 2) && b != 0 && layers_r != 0 && !off_p
                && s_sub != -1) begin
            chg = 0;
            if (prev_rate > 0) begin
                chg = (b * 100 * 65536) / prev_rate - 100 * 65536;
                if (chg > 2147483647) chg = 2147483647;
            end
            cur = layer_pos(s_sub, s_tmp);
            req = layer_pos(w_pend == -1 ? w_sub : w_pend, w_tmp);
            low_t = (w_tmp == 0 || w_tmp == 1);
            if (req != last_req) begin
                last_req = req;
                if (req < cur) begin
                    fail_pos = -1; fail_cnt = 0; ramp_t = 0;
                end
            end
            lo = cur;
            hi = cur;
            if (lo > 0) begin
                lo--;
                if ((lo & 1) && low_t) lo--;
                if (lo < 0) lo = 0;
            end
            if (hi < 5) begin
                stp = (w_sub == -1) ? 2 : w_sub;
                hi++;
                if ((hi & 1) && low_t) hi++;
                if (hi > 3 && stp < 2) hi = 0;
                else if (hi > 1 && stp < 1) hi = 0;
            end
            cr = pos_rate(cur);
            hr = (hi > cur) ? pos_rate(hi) : 0;
            if (prev_ok) begin
                cv = (chg > avg_chg) ? chg : avg_chg;
                if (cur > 0 && b < cr) begin
                    if (5 * b < 4 * cr && 5 * cv < 65536) sw_cnt -= 4;
                    else if (10 * b < 9 * cr && 2 * cv < 65536) sw_cnt -= 2;
                    else if (cv < 65536) sw_cnt -= 1;
                end else if (b > cr) begin
                    if (sw_cnt < 0) sw_cnt++;
                    if (hr != 0 && b > hr) begin
                        if (5 * b > 6 * hr) sw_cnt += 4;
                        else if (10 * b > 11 * hr) sw_cnt += 2;
                        else sw_cnt += 1;
                    end
                end
                if (sw_cnt > 23) sw_cnt = 23;
                if (sw_cnt < -23) sw_cnt = -23;
            end
            dt = 0;
            if (ramp_t != 0) begin
                dt = (longint'(w.now) - ramp_t) & TIME_MASK;
                if (fail_pos >= 0 && dt > 7000000 && cur >= fail_pos) begin
                    fail_pos = -1; fail_cnt = 0;
                end
            end
            if (sw_cnt <= -20 || sw_cnt >= 20) begin
                if (w.sim) begin
                    if (sw_cnt < 0) begin
                        if (ramp_t != 0) begin
                            if (dt < 7000000) begin
                                fail_pos = cur;
                                if (fail_cnt < 255) fail_cnt++;
                                fl = 1;
                            end
                            ramp_t = 0;
                        end
                        if (load_caps(lo)) sw = 1;
                    end else if (load_caps(hi)) begin
                        ramp_t = w.now;
                        sw = 1; up = 1;
                    end
                    sw_cnt = 0;
                end else begin
                    off_p = 1;
                end
            end
            avg = avg_chg;
            if (avg != 0) avg = (avg + chg) / 2;
            else avg = chg;
            avg_chg = avg;
        end
        if (b != 0) begin
            prev_rate = b;
            prev_ok = 1;
        end
        r.sub = 3'(sub_cap_p); r.tmp = 3'(temp_cap_p); r.sw = sw; r.up = up; r.fl = fl;
        r.lvl = 6'(sw_cnt); r.dis = off_p;
        return r;
    endfunction

    function automatic void compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic send_word(t_report w, bit has_exp, t_caps exp_v);
        bit    ok;
        t_caps pr;
        while ((idle_mode == 1 && $urandom_range(99) < 72)
                || (idle_mode == 3 && $urandom_range(99) < 15)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_est_rate <= w.est;
        i_now_us <= w.now;
        i_sent_substream <= w.ss;
        i_sent_temporal <= w.st;
        i_want_substream <= w.ws;
        i_want_substream_pending <= w.wp;
        i_want_temporal <= w.wt;
        i_source_simulcasts <= w.sim;
        do begin
            @(negedge i_clk);
            ok = !o_stall;
            @(posedge i_clk);
        end while (!ok);
        pr = ramp_predict(w);
        caps_due.push_back(has_exp ? exp_v : pr);
        words_in++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (caps_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d[27:0];
        @(posedge i_clk);
        model_write(idx, d[27:0]);
    endtask

    // Receiver side: random stalls per phase, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            case (idle_mode)
                2: i_stall <= ($urandom_range(99) < 72);
                3: i_stall <= ($urandom_range(99) < 15);
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // Output check and watchdog, sampled mid-cycle where everything is stable.
    always @(negedge i_clk) begin
        t_caps e;
        if (i_rst_n && o_valid && !i_stall) begin
            words_out++;
            if (caps_due.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
            end else begin
                e = caps_due.pop_front();
                compare_field("substream_cap", e.sub, o_substream_cap);
                compare_field("temporal_cap", e.tmp, o_temporal_cap);
                compare_field("switched", e.sw, o_switched);
                compare_field("switched_up", e.up, o_switched_up);
                compare_field("ramp_failed", e.fl, o_ramp_failed);
                compare_field("hysteresis_level", e.lvl, o_hysteresis_level);
                compare_field("disabled", e.dis, o_disabled);
                switches += e.sw;
                ups += e.up;
                fails += e.fl;
            end
        end
        if ((o_valid && !i_stall) || (i_valid && !o_stall)) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_CYCLES) begin
            $display("%0t: no progress for %0d cycles", $time, quiet);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic t_report mk(longint est, longint now, int ss, int st, int ws,
                                   int wp, int wt, bit sim);
        t_report w;
        w.est = 28'(est); w.now = 48'(now); w.ss = 3'(ss); w.st = 3'(st);
        w.ws = 3'(ws); w.wp = 3'(wp); w.wt = 3'(wt); w.sim = sim;
        return w;
    endfunction

    function automatic t_caps idle_caps();
        t_caps c;
        c = '0;
        c.sub = -1;
        c.tmp = -1;
        return c;
    endfunction

    t_row dir_rows[$];

    initial begin
        t_report w;
        t_caps   none;
        int      target, ws_t, wt_t, seq_left, n_items;
        longint  base, est;
        none = '0;
        model_reset();

        // Ignoring reports after reset: caps stay open, nothing moves.
        dir_rows.push_back('{mk(RATE_MAX, 1000, 2, 2, -1, -1, -1, 1), 1'b1, idle_caps()});
        dir_rows.push_back('{mk(0, 2000, 0, 0, 0, 0, 0, 0), 1'b1, idle_caps()});
        dir_rows.push_back('{mk(1, 3000, -1, -1, 2, 2, 2, 1), 1'b1, idle_caps()});
        // Active rows, from here on the first ramp-up configuration.
        dir_rows.push_back('{mk(500000, 10000, 0, 1, -1, -1, -1, 1), 1'b0, none});
        dir_rows.push_back('{mk(RATE_MAX, 20000, 0, 1, -1, -1, -1, 1), 1'b0, none});
        dir_rows.push_back('{mk(0, 30000, 0, 1, -1, -1, -1, 1), 1'b0, none});
        dir_rows.push_back('{mk(1, 40000, 0, 1, -1, -1, -1, 1), 1'b0, none});
        dir_rows.push_back('{mk(900000, 50000, -1, 2, -1, -1, -1, 1), 1'b0, none});
        dir_rows.push_back('{mk(900000, 60000, 3, -2, 3, -1, 1, 1), 1'b0, none});
        dir_rows.push_back('{mk(900000, 70000, -4, 3, -4, 1, 0, 1), 1'b0, none});
        dir_rows.push_back('{mk(3000000, 80000, 1, 2, 0, 2, -4, 1), 1'b0, none});
        dir_rows.push_back('{mk(8000000, 90000, 2, -1, 2, -1, 2, 1), 1'b0, none});
        dir_rows.push_back('{mk(200000, 48'hFFFF_FFFF_FFFF, 2, 2, 2, -1, -1, 1),
                            1'b0, none});
        dir_rows.push_back('{mk(RATE_MAX, 0, 1, 0, -1, 0, 1, 1), 1'b0, none});
        for (int k = 0; k < 6; k++)
            dir_rows.push_back('{mk(RATE_MAX, 100000 + k, 0, 0, -1, -1, -1, 0), 1'b0, none});
        dir_rows.push_back('{mk(400000, 200000, 1, 1, -1, -1, -1, 1), 1'b0, none});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (i == 3) begin
                drain();
                write_reg(REG_MODE, 1);
                write_reg(REG_LAYERS, 3);
                write_reg(REG_LOW, 1000000);
                write_reg(REG_MID, 2000000);
                write_reg(REG_HIGH, 4000000);
                i_cfg_we <= 1'b0;
            end
            send_word(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].exp);
        end
        drain();

        t_now = 1000000;
        for (int p = 0; p < 12; p++) begin
            idle_mode = p % 4;
            write_reg(REG_MODE, (p == 3) ? 0 : (p == 9) ? 3 : (p % 2) ? 1 : 2);
            write_reg(REG_LAYERS, (p == 6) ? 0 : (p % 3) + 1);
            if (p == 1) begin
                write_reg(REG_LOW, 0); write_reg(REG_MID, 0); write_reg(REG_HIGH, 0);
            end else if (p == 2) begin
                write_reg(REG_LOW, RATE_MAX); write_reg(REG_MID, RATE_MAX);
                write_reg(REG_HIGH, RATE_MAX);
            end else if (p == 5) begin
                write_reg(REG_LOW, 1); write_reg(REG_MID, 2); write_reg(REG_HIGH, 3);
            end else begin
                base = $urandom_range(100000, 2000000);
                write_reg(REG_LOW, base);
                write_reg(REG_MID, base * 2 + $urandom_range(0, 500000));
                write_reg(REG_HIGH, base * 5 + $urandom_range(0, 2000000));
            end
            i_cfg_we <= 1'b0;
            n_items = (p == 3 || p == 6 || p == 9) ? 20 : 170;
            if (p == 4) hold_cycles = 400;
            seq_left = 0;
            target = 0; ws_t = -1; wt_t = -1;
            for (int n = 0; n < n_items; n++) begin
                if (seq_left == 0) begin
                    seq_left = $urandom_range(15, 45);
                    target = $urandom_range(0, 5);
                    ws_t = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : -1;
                    wt_t = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : -1;
                end
                seq_left--;
                t_now += ($urandom_range(0, 9) == 0) ? $urandom_range(7000000, 9000000)
                                                     : $urandom_range(50000, 1500000);
                if ($urandom_range(0, 199) == 0) t_now = TIME_MASK - $urandom_range(0, 999999);
                t_now &= TIME_MASK;
                base = (target < 2) ? rate_lo : (target < 4) ? rate_mid : rate_hi;
                if (!(target & 1)) base = base * 3 / 5;
                est = base * $urandom_range(60, 150) / 100;
                if (est > RATE_MAX) est = RATE_MAX;
                if (est <= 0) est = $urandom_range(1, 5000000);
                if ($urandom_range(0, 9) == 0) begin
                    w = 95'({$urandom, $urandom, $urandom});
                    w.now = 48'(t_now);
                end else begin
                    w = mk(($urandom_range(0, 49) == 0) ? 0 : est, t_now,
                           (sub_cap_p == -1) ? 2 : sub_cap_p,
                           (temp_cap_p == -1) ? ($urandom_range(0, 1) ? 2 : -1)
                                              : $urandom_range(0, 1),
                           ws_t, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : -1,
                           wt_t, $urandom_range(0, 49) != 0);
                end
                send_word(w, 1'b0, none);
            end
            drain();
        end

        $display("Sent %0d report words and checked %0d results over 12 register settings.",
                 words_in, words_out);
        $display("Seen %0d layer switches, %0d ramp ups and %0d failed ramp ups.",
                 switches, ups, fails);
        if (errors == 0 && caps_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
